[rtl/uv5_pkg.sv]
package uv5_pkg;
  localparam int MAX_NAME_BYTES = 96;
  localparam int NAME_CNT_W = $clog2(MAX_NAME_BYTES + 2);
  localparam int TOTAL_W = $clog2(MAX_NAME_BYTES + 17);
  localparam logic [NAME_CNT_W-1:0] NAME_LIMIT = NAME_CNT_W'(MAX_NAME_BYTES);
  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hEFCDAB89;
  localparam logic [31:0] H2 = 32'h98BADCFE;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hC3D2E1F0;
  localparam logic [7:0] VER_MASK = 8'h0f;
  localparam logic [7:0] VER_SET = 8'h50;
  localparam logic [7:0] VAR_MASK = 8'h3f;
  localparam logic [7:0] VAR_SET = 8'h80;
  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic REG_NS_HIGH = 1'b0;
  localparam logic REG_NS_LOW = 1'b1;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
    rotl = (x << n) | (x >> (32 - n));
  endfunction
endpackage

[rtl/uv5_ram.sv]
module uv5_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[rtl/uv5_round.sv]
module uv5_round import uv5_pkg::*; (
  input  logic [6:0]  rnd,
  input  logic [31:0] a,
  input  logic [31:0] b,
  input  logic [31:0] c,
  input  logic [31:0] d,
  input  logic [31:0] e,
  input  logic [31:0] w,
  output logic [31:0] t
);
  logic [31:0] f;
  logic [31:0] k;

  always_comb begin
    if (rnd < 7'd20) begin
      f = (b & c) | (~b & d);
      k = 32'h5A827999;
    end else if (rnd < 7'd40) begin
      f = b ^ c ^ d;
      k = 32'h6ED9EBA1;
    end else if (rnd < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
      k = 32'h8F1BBCDC;
    end else begin
      f = b ^ c ^ d;
      k = 32'hCA62C1D6;
    end
    t = rotl(a, 5) + f + e + k + w;
  end
endmodule

[rtl/uuid_v5_generator.sv]
// A name byte word is taken only in idle; its byte goes into the buffer RAM in S_BYTE, and
// the first word of a name first puts the 16 namespace bytes into it, one a cycle.
// Each full 64-byte block is loaded from the RAM into the schedule window, then runs
// 80 rounds at one a cycle, updates the chaining words and resumes.
// out_valid rises once padding (one or two blocks, none for an overlong name) is hashed.
// Synchronous active-high reset restores the chaining values; the buffer RAM is not cleared.
module uuid_v5_generator import uv5_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  name_byte,
  input  logic        byte_present,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] uuid_high,
  output logic [63:0] uuid_low,
  output logic        status
);
  typedef enum logic [3:0] {
    S_IDLE, S_NS, S_BYTE, S_NEXT, S_PAD, S_LOAD, S_ROUND, S_FIN, S_OUT
  } state_t;

  state_t state;
  logic [63:0] ns_high, ns_low;
  logic [31:0] h [5];
  logic [31:0] a, b, c, d, e;
  logic [31:0] win [16];
  logic [31:0] wacc;
  logic [5:0] mcount;
  logic [NAME_CNT_W-1:0] ncount;
  logic [TOTAL_W-1:0] total;
  logic [7:0] byte_q;
  logic present_q, closing, ns_done, over, pad_done, len_ok, len_done;
  logic [3:0] nsi;
  logic [4:0] ld;
  logic [6:0] rnd;

  logic take;
  logic we;
  logic [7:0] cur_byte;
  logic [31:0] wmerge, wnew, t, rdata;
  logic [63:0] len_bits;
  logic [7:0] d6, d8;

  // block buffer: 16 x 32, bytes merged through wacc in order
  uv5_ram #(.WIDTH(32), .DEPTH(16)) u_buf (
    .clk(clk), .we(we), .waddr(mcount[5:2]), .wdata(wmerge), .raddr(ld[3:0]),
    .rdata(rdata)
  );

  // schedule window shifts once a round, win[0] is the current word
  assign wnew = rotl(win[13] ^ win[8] ^ win[2] ^ win[0], 1);

  uv5_round u_round (
    .rnd(rnd), .a(a), .b(b), .c(c), .d(d), .e(e), .w(win[0]), .t(t)
  );

  assign take = byte_present && (ncount < NAME_LIMIT);
  assign we = (state == S_NS) || (state == S_BYTE) || (state == S_PAD);
  assign in_stall = (state != S_IDLE);
  assign len_bits = 64'({total, 3'b000});

  always_comb begin
    case (state)
      S_NS: cur_byte = nsi[3] ? ns_low[{~nsi[2:0], 3'b000} +: 8] :
                                ns_high[{~nsi[2:0], 3'b000} +: 8];
      S_BYTE: cur_byte = byte_q;
      S_PAD: begin
        if (!pad_done) cur_byte = PAD_BYTE;
        else if (len_ok && mcount >= 6'd56) cur_byte = len_bits[{~mcount[2:0], 3'b000} +: 8];
        else cur_byte = 8'd0;
      end
      default: cur_byte = 8'd0;
    endcase
  end

  always_comb begin
    wmerge = wacc;
    case (mcount[1:0])
      2'd0: wmerge = {cur_byte, 24'd0};
      2'd1: wmerge[23:16] = cur_byte;
      2'd2: wmerge[15:8] = cur_byte;
      default: wmerge[7:0] = cur_byte;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ns_high <= '0;
      ns_low <= '0;
      h[0] <= H0; h[1] <= H1; h[2] <= H2; h[3] <= H3; h[4] <= H4;
      wacc <= '0;
      mcount <= '0; ncount <= '0; total <= '0;
      present_q <= 1'b0; closing <= 1'b0; ns_done <= 1'b0; over <= 1'b0;
      pad_done <= 1'b0; len_ok <= 1'b0; len_done <= 1'b0;
      nsi <= '0; ld <= '0; rnd <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_NS_HIGH) ns_high <= cfg_data;
        else if (cfg_index == REG_NS_LOW) ns_low <= cfg_data;
      end
      if (we) begin
        wacc <= wmerge;
        mcount <= mcount + 6'd1;
      end
      case (state)
        S_IDLE: begin
          if (in_valid && (byte_present || last_byte)) begin
            byte_q <= name_byte;
            present_q <= take;
            closing <= last_byte;
            if (byte_present && !take) over <= 1'b1;
            if (!ns_done) begin
              ns_done <= 1'b1;
              nsi <= '0;
              state <= S_NS;
            end else state <= S_NEXT;
          end
        end
        S_NS: begin
          total <= total + TOTAL_W'(1);
          nsi <= nsi + 4'd1;
          if (nsi == 4'd15) state <= S_NEXT;
        end
        S_BYTE: begin
          total <= total + TOTAL_W'(1);
          ncount <= ncount + NAME_CNT_W'(1);
          present_q <= 1'b0;
          if (mcount == 6'd63) state <= S_LOAD;
          else if (closing) state <= S_NEXT;
          else state <= S_IDLE;
        end
        S_NEXT: begin
          if (present_q) state <= S_BYTE;
          else if (closing && (over || len_done)) begin
            state <= S_OUT;
            out_valid <= 1'b1;
          end else if (closing) state <= S_PAD;
          else state <= S_IDLE;
        end
        S_PAD: begin
          // length goes in this block only if the pad byte leaves room for it
          if (!pad_done) begin
            pad_done <= 1'b1;
            len_ok <= (mcount <= 6'd55);
          end
          if (mcount == 6'd63) state <= S_LOAD;
        end
        S_LOAD: begin
          if (ld != 5'd0) win[ld[3:0] - 4'd1] <= rdata;
          if (ld == 5'd16) begin
            ld <= '0;
            rnd <= '0;
            state <= S_ROUND;
            a <= h[0]; b <= h[1]; c <= h[2]; d <= h[3]; e <= h[4];
          end else ld <= ld + 5'd1;
        end
        S_ROUND: begin
          e <= d; d <= c; c <= rotl(b, 30); b <= a; a <= t;
          for (int i = 0; i < 15; i++) win[i] <= win[i+1];
          win[15] <= wnew;
          rnd <= rnd + 7'd1;
          if (rnd == 7'd79) state <= S_FIN;
        end
        S_FIN: begin
          h[0] <= h[0] + a; h[1] <= h[1] + b; h[2] <= h[2] + c;
          h[3] <= h[3] + d; h[4] <= h[4] + e;
          if (pad_done && len_ok) len_done <= 1'b1;
          else if (pad_done) len_ok <= 1'b1;
          state <= S_NEXT;
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            state <= S_IDLE;
            h[0] <= H0; h[1] <= H1; h[2] <= H2; h[3] <= H3; h[4] <= H4;
            mcount <= '0; ncount <= '0; total <= '0;
            present_q <= 1'b0; closing <= 1'b0; ns_done <= 1'b0; over <= 1'b0;
            pad_done <= 1'b0; len_ok <= 1'b0; len_done <= 1'b0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign d6 = (h[1][15:8] & VER_MASK) | VER_SET;
  assign d8 = (h[2][31:24] & VAR_MASK) | VAR_SET;
  assign uuid_high = over ? 64'd0 : {h[0], h[1][31:16], d6, h[1][7:0]};
  assign uuid_low = over ? 64'd0 : {d8, h[2][23:0], h[3]};
  assign status = over;

`ifndef SYNTHESIS
  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> in_stall) else $error("accepted while busy");
  a_out_state: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (state == S_OUT)) else $error("result outside output state");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(uuid_high) &&
    $stable(uuid_low) && $stable(status))) else $error("stalled result changed");
  a_name_cnt: assert property (@(posedge clk) disable iff (rst)
    ncount <= NAME_LIMIT) else $error("name count overrun");
`endif
endmodule

[verif/uuid_checker.sv]
module uuid_checker import uv5_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  name_byte,
  input  logic        byte_present,
  input  logic        last_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [63:0] uuid_high,
  input  logic [63:0] uuid_low,
  input  logic        status,
  output int          errors,
  output int          pending
);

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
    logic        st;
  } uuid_t;

  uuid_t       uuid_q[$];
  logic [63:0] ns_hi, ns_lo;
  logic [31:0] chain[5];
  logic [7:0]  blk[64];
  int          blk_pos, msg_len, name_cnt;
  logic        ns_loaded, too_long;

  function automatic logic [31:0] rol(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  task automatic sha_start();
    chain[0] = H0; chain[1] = H1; chain[2] = H2; chain[3] = H3; chain[4] = H4;
    blk_pos = 0; msg_len = 0; name_cnt = 0;
    ns_loaded = 0; too_long = 0;
  endtask

  task automatic sha_block();
    logic [31:0] w[80];
    logic [31:0] a, b, c, d, e, f, k, t;
    for (int i = 0; i < 16; i++)
      w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    for (int i = 16; i < 80; i++)
      w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
    a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
    for (int i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d); k = 32'h5A827999;
      end else if (i < 40) begin
        f = b ^ c ^ d; k = 32'h6ED9EBA1;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
      end else begin
        f = b ^ c ^ d; k = 32'hCA62C1D6;
      end
      t = rol(a, 5) + f + e + k + w[i];
      e = d; d = c; c = rol(b, 30); b = a; a = t;
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
  endtask

  task automatic sha_byte(input logic [7:0] v);
    blk[blk_pos] = v;
    blk_pos++;
    msg_len++;
    if (blk_pos == 64) begin
      sha_block();
      blk_pos = 0;
    end
  endtask

  task automatic sha_close(output uuid_t r);
    logic [63:0] bits;
    logic [7:0]  dg[16];
    bits = 64'(msg_len) * 8;
    blk[blk_pos] = PAD_BYTE;
    blk_pos++;
    if (blk_pos > 56) begin
      while (blk_pos < 64) begin
        blk[blk_pos] = 8'h00; blk_pos++;
      end
      sha_block();
      blk_pos = 0;
    end
    while (blk_pos < 56) begin
      blk[blk_pos] = 8'h00; blk_pos++;
    end
    for (int i = 0; i < 8; i++) blk[56+i] = bits[63-8*i -: 8];
    sha_block();
    for (int i = 0; i < 16; i++) dg[i] = chain[i/4][31-8*(i%4) -: 8];
    dg[6] = (dg[6] & VER_MASK) | VER_SET;
    dg[8] = (dg[8] & VAR_MASK) | VAR_SET;
    for (int i = 0; i < 8; i++) begin
      r.hi[63-8*i -: 8] = dg[i];
      r.lo[63-8*i -: 8] = dg[8+i];
    end
    r.st = 1'b0;
  endtask

  task automatic take_word(input logic [7:0] nb, input logic pres, input logic fin);
    uuid_t r;
    if (!pres && !fin) return;
    if (!ns_loaded) begin
      for (int i = 0; i < 8; i++) sha_byte(ns_hi[63-8*i -: 8]);
      for (int i = 0; i < 8; i++) sha_byte(ns_lo[63-8*i -: 8]);
      ns_loaded = 1;
    end
    if (pres) begin
      if (name_cnt < MAX_NAME_BYTES) begin
        sha_byte(nb);
        name_cnt++;
      end else begin
        too_long = 1;
      end
    end
    if (!fin) return;
    if (too_long) r = '{hi: 64'd0, lo: 64'd0, st: 1'b1};
    else sha_close(r);
    uuid_q.push_back(r);
    sha_start();
  endtask

  initial begin
    errors = 0;
    pending = 0;
    ns_hi = '0;
    ns_lo = '0;
    sha_start();
  end

  always @(posedge clk) begin
    uuid_t x;
    if (rst) begin
      ns_hi = '0;
      ns_lo = '0;
      sha_start();
      uuid_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (uuid_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected word hi=%h lo=%h st=%b", $time,
                   uuid_high, uuid_low, status);
        end else begin
          x = uuid_q.pop_front();
          if (uuid_high !== x.hi) begin
            errors++;
            $display("%0t: uuid_high exp %h got %h", $time, x.hi, uuid_high);
          end
          if (uuid_low !== x.lo) begin
            errors++;
            $display("%0t: uuid_low exp %h got %h", $time, x.lo, uuid_low);
          end
          if (status !== x.st) begin
            errors++;
            $display("%0t: status exp %b got %b", $time, x.st, status);
          end
        end
      end
      if (cfg_we) begin
        if (cfg_index == REG_NS_HIGH) ns_hi = cfg_data;
        else if (cfg_index == REG_NS_LOW) ns_lo = cfg_data;
      end
      if (in_valid && !in_stall) take_word(name_byte, byte_present, last_byte);
    end
    pending = uuid_q.size();
  end

endmodule

[verif/tb.sv]
module tb import uv5_pkg::*; ();

  localparam int LIMIT = 4000000;

  logic        clk, rst;
  logic        cfg_we, cfg_index;
  logic [63:0] cfg_data;
  logic        in_valid, in_stall;
  logic [7:0]  name_byte;
  logic        byte_present, last_byte;
  logic        out_valid, out_stall;
  logic [63:0] uuid_high, uuid_low;
  logic        status;
  int          errors, pending;
  int          tx_pct, rx_pct, sent, cyc, hold_cnt;
  logic        hold_go, hold_done;

  uuid_v5_generator u_top (.*);

  uuid_checker u_chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc >= LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver, with one long hold-off so the block backs up
  always @(posedge clk) begin
    if (hold_cnt > 0) begin
      out_stall <= 1'b1;
      hold_cnt <= hold_cnt - 1;
    end else if (hold_go && !hold_done) begin
      out_stall <= 1'b1;
      hold_cnt <= 600;
      hold_done <= 1'b1;
    end else begin
      out_stall <= (rx_pct > 0) && ($urandom_range(0, 99) < rx_pct);
    end
  end

  task automatic send(input logic [7:0] b, input logic p, input logic l);
    while ((tx_pct > 0) && ($urandom_range(0, 99) < tx_pct)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    name_byte <= b;
    byte_present <= p;
    last_byte <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  task automatic send_name(input int len, input logic bare_close);
    for (int i = 0; i < len; i++)
      send(8'($urandom_range(0, 255)), 1'b1, !bare_close && (i == len - 1));
    if (bare_close || len == 0) send(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [63:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_names(input int n);
    int len, r;
    int stop;
    stop = sent + n;
    while (sent < stop) begin
      r = $urandom_range(0, 99);
      if (r < 70) len = $urandom_range(0, 24);
      else if (r < 85) len = $urandom_range(25, 60);
      else if (r < 95) len = $urandom_range(61, MAX_NAME_BYTES);
      else len = $urandom_range(MAX_NAME_BYTES + 1, MAX_NAME_BYTES + 12);
      if ($urandom_range(0, 9) == 0) send(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 15) == 0) send(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        send(8'($urandom_range(0, 255)), 1'b1, (i == len - 1) && ($urandom_range(0, 4) != 0));
        if (last_byte) break;
      end
      if (len == 0 || !last_byte) send(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0; cfg_index = REG_NS_HIGH; cfg_data = '0;
    in_valid = 1'b0; name_byte = '0; byte_present = 1'b0; last_byte = 1'b0;
    out_stall = 1'b0;
    tx_pct = 0; rx_pct = 0; sent = 0; cyc = 0; hold_cnt = 0;
    hold_go = 1'b0; hold_done = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: namespace zero
    send(8'h00, 1'b0, 1'b1);
    send(8'h61, 1'b1, 1'b0);
    send(8'h00, 1'b0, 1'b0);
    send(8'h62, 1'b1, 1'b0);
    send(8'hff, 1'b1, 1'b1);
    send(8'h00, 1'b1, 1'b0);
    send(8'h7f, 1'b0, 1'b1);
    drain();
    write_reg(REG_NS_HIGH, '1);
    write_reg(REG_NS_LOW, '1);
    send(8'hff, 1'b0, 1'b1);
    send_name(39, 1'b0);
    send_name(40, 1'b1);
    send_name(48, 1'b0);
    send_name(MAX_NAME_BYTES, 1'b0);
    send_name(MAX_NAME_BYTES + 1, 1'b0);
    drain();

    tx_pct = 28; rx_pct = 45;
    write_reg(REG_NS_HIGH, 64'h6ba7b8109dad11d1);
    write_reg(REG_NS_LOW, 64'h80b400c04fd430c8);
    random_names(300);
    drain();
    write_reg(REG_NS_HIGH, {$urandom, $urandom});
    write_reg(REG_NS_LOW, {$urandom, $urandom});
    random_names(300);
    drain();

    tx_pct = 45; rx_pct = 28;
    write_reg(REG_NS_HIGH, 64'd0);
    write_reg(REG_NS_LOW, '1);
    hold_go <= 1'b1;
    random_names(300);
    drain();
    write_reg(REG_NS_HIGH, '1);
    write_reg(REG_NS_LOW, 64'd0);
    random_names(300);
    drain();

    tx_pct = 0; rx_pct = 0;
    write_reg(REG_NS_HIGH, {$urandom, $urandom});
    write_reg(REG_NS_LOW, {$urandom, $urandom});
    random_names(300);
    drain();

    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

[sim.f]
rtl/uv5_pkg.sv
rtl/uv5_ram.sv
rtl/uv5_round.sv
rtl/uuid_v5_generator.sv
verif/uuid_checker.sv
verif/tb.sv
